### sv/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, register indexes and small helpers of the height blur and
// steepness stream core.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int DIM_W   = 11;
    localparam int SCALE_W = 16;
    localparam int OUT_W   = 16;

    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [1:0]         mod3_t;
    typedef logic [1:0]         cfg_idx_t;
    typedef logic [SCALE_W-1:0] scale_t;

    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_STEEP_SCALE  = 2'd2;

    localparam dim_t   RST_FRAME_DIM   = 11'd1024;
    localparam scale_t RST_STEEP_SCALE = 16'd256;

    function automatic mod3_t mod3_inc(input mod3_t v);
        mod3_inc = (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    function automatic mod3_t mod3_dec(input mod3_t v);
        mod3_dec = (v == 2'd0) ? 2'd2 : v - 2'd1;
    endfunction

endpackage

### sv/height_blur_steepness_stream_core.sv
// ----------------------------------------------------------------------------
// height_blur_steepness_stream_core
// Two-pass separable 3x3 box blur of a height raster with a steepness measure.
// A taken transfer occupies the block from its read steps through its output step;
// ready returns only in the idle state, so no new item is accepted before the
// last one is through. An ignored transfer is consumed without leaving idle.
// The three single-port line buffers are each visited several times per pixel.
// A result is registered in the output step of the transfer that completes it,
// which comes 3*W+3 taken items after its pixel; drain items follow the frame. A
// stalled output holds the block in its last step until the result moves.
// Reset clears the positions and loads the register defaults; the line
// buffers need no clearing, since every value used was written in the same frame.
// ----------------------------------------------------------------------------
module height_blur_steepness_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  hbs_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // height_in
    input  logic              s_axis_tuser,   // req_type
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // smoothed_height, steepness
    output logic              m_axis_tlast    // last_pixel
);
    import hbs_pkg::*;

    localparam int AW    = $clog2(3*MAX_WIDTH);
    localparam int DEPTH = 3*MAX_WIDTH;
    localparam int VW    = 8 + FRAC_BITS;
    localparam int SW    = VW + 2;
    localparam int KSH   = SW + 1;
    localparam int PW    = SW + KSH;
    localparam int RECIP = (2**KSH + 2) / 3;
    localparam int MW    = VW + SCALE_W;
    localparam int TW    = $clog2(MAX_WIDTH*MAX_HEIGHT + 3*MAX_WIDTH + 4);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_RD2  = 4'd2;
    localparam logic [3:0] S_RD3  = 4'd3;
    localparam logic [3:0] S_RD4  = 4'd4;
    localparam logic [3:0] S_RD5  = 4'd5;
    localparam logic [3:0] S_W6   = 4'd6;
    localparam logic [3:0] S_W7   = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    function automatic logic [VW-1:0] div_taps(input logic [SW-1:0] s, input logic [1:0] k);
        logic [SW-1:0] s1;
        logic [PW-1:0] p;
        s1 = s + SW'(1);
        p  = PW'(s1) * PW'(RECIP);
        case (k)
            2'd3:    div_taps = VW'(p >> KSH);
            2'd2:    div_taps = VW'(s1 >> 1);
            default: div_taps = VW'(s);
        endcase
    endfunction

    logic [3:0]    state_reg, state_next;
    dim_t          cfg_w_reg, cfg_h_reg;
    scale_t        scale_reg;
    dim_t          w, h;
    logic [TW-1:0] t_reg;
    logic          act_p_reg, act_a_reg, act_b_reg, act_c_reg, act_d_reg, act_e_reg;
    logic          act_a, act_b, act_c, act_d, act_e;

    logic [VW-1:0] raw_win [0:2];
    logic [VW-1:0] mid_win [0:2];
    logic [VW-1:0] va_reg, vb_reg, vc_reg, vd_reg;
    logic [VW-1:0] fpb0_reg, spd0_reg, spd1_reg;
    logic [VW-1:0] smc_reg, sml_reg, smr_reg, smu_reg, smd_reg;
    logic [VW-1:0] d_reg;
    logic [OUT_W-1:0] st_reg;
    logic [OUT_W-1:0] out_h_reg, out_s_reg;
    logic          out_valid_reg, out_last_reg;

    logic [VW-1:0] fp_mem [0:DEPTH-1];
    logic [VW-1:0] sp_mem [0:DEPTH-1];
    logic [VW-1:0] sm_mem [0:DEPTH-1];
    logic [VW-1:0] fp_rdata_reg, sp_rdata_reg, sm_rdata_reg;
    logic [AW-1:0] fp_addr, sp_addr, sm_addr;
    logic          fp_we, sp_we, sm_we;
    logic [VW-1:0] sm_wdata;

    logic          frame_clr, done, is_last, in_frame, accept, take;
    dim_t          xp, yp, xa, ya, xb, yb, xc, yc, xd, yd, xe, ye;
    mod3_t         mp, ma, mb, mc, md, me;
    logic [AW-1:0] ap, apu, apd, aa, aau, aad, ab, abu, abd;
    logic [AW-1:0] ac, acu, acd, ad, adu, add, ae, aeu, aed;

    logic [SW-1:0] sum_a, sum_b, sum_c, sum_d;
    logic [1:0]    k_a, k_b, k_c, k_d;
    logic [VW-1:0] e_r, e_l, e_u, e_d, dmax;
    logic [MW-1:0] prod;
    logic [MW-1:0] st_full;

    assign w = (cfg_w_reg == '0) ? dim_t'(1) :
               ((32'(cfg_w_reg) > MAX_WIDTH) ? dim_t'(MAX_WIDTH) : cfg_w_reg);
    assign h = (cfg_h_reg == '0) ? dim_t'(1) :
               ((32'(cfg_h_reg) > MAX_HEIGHT) ? dim_t'(MAX_HEIGHT) : cfg_h_reg);

    assign in_frame = (yp < h);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign take     = in_frame ? !s_axis_tuser : s_axis_tuser;
    assign is_last  = (xe + 1'b1 == w) && (ye + 1'b1 == h);
    assign done     = (state_reg == S_OUT) && (!act_e_reg || !out_valid_reg || m_axis_tready);
    assign frame_clr = (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT))
                       || (done && act_e_reg && is_last);

    assign act_a = (t_reg >= TW'(1)) && (ya < h);
    assign act_b = (t_reg >= TW'(w) + TW'(1)) && (yb < h);
    assign act_c = (t_reg >= TW'(w) + TW'(2)) && (yc < h);
    assign act_d = (t_reg >= TW'(w) * TW'(2) + TW'(2)) && (yd < h);
    assign act_e = (t_reg >= TW'(w) * TW'(3) + TW'(3)) && (ye < h);

    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_p (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_p_reg), .w(w),
        .x(xp), .y(yp), .addr(ap), .addr_up(apu), .addr_dn(apd), .m3(mp));
    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_a (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_a_reg), .w(w),
        .x(xa), .y(ya), .addr(aa), .addr_up(aau), .addr_dn(aad), .m3(ma));
    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_b (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_b_reg), .w(w),
        .x(xb), .y(yb), .addr(ab), .addr_up(abu), .addr_dn(abd), .m3(mb));
    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_c (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_c_reg), .w(w),
        .x(xc), .y(yc), .addr(ac), .addr_up(acu), .addr_dn(acd), .m3(mc));
    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_d (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_d_reg), .w(w),
        .x(xd), .y(yd), .addr(ad), .addr_up(adu), .addr_dn(add), .m3(md));
    hbs_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos_e (
        .clk(clk), .rst_n(rst_n), .clear(frame_clr), .step(done && act_e_reg), .w(w),
        .x(xe), .y(ye), .addr(ae), .addr_up(aeu), .addr_dn(aed), .m3(me));

    // Window sums of the four averages.
    always_comb
    begin
        sum_a = SW'(raw_win[ma])
              + ((xa != '0) ? SW'(raw_win[mod3_dec(ma)]) : SW'(0))
              + ((xa + 1'b1 < w) ? SW'(raw_win[mod3_inc(ma)]) : SW'(0));
        k_a   = 2'd1 + 2'(xa != '0) + 2'(xa + 1'b1 < w);
        sum_b = SW'(fpb0_reg)
              + ((yb != '0) ? SW'(fp_rdata_reg) : SW'(0))
              + ((yb + 1'b1 < h) ? SW'(va_reg) : SW'(0));
        k_b   = 2'd1 + 2'(yb != '0) + 2'(yb + 1'b1 < h);
        sum_c = SW'(mid_win[mc])
              + ((xc != '0) ? SW'(mid_win[mod3_dec(mc)]) : SW'(0))
              + ((xc + 1'b1 < w) ? SW'(mid_win[mod3_inc(mc)]) : SW'(0));
        k_c   = 2'd1 + 2'(xc != '0) + 2'(xc + 1'b1 < w);
        sum_d = SW'(spd0_reg)
              + ((yd != '0) ? SW'(spd1_reg) : SW'(0))
              + ((yd + 1'b1 < h) ? SW'(vc_reg) : SW'(0));
        k_d   = 2'd1 + 2'(yd != '0) + 2'(yd + 1'b1 < h);
    end

    always_comb
    begin
        e_r  = (xe + 1'b1 < w) ? ((smr_reg > smc_reg) ? smr_reg - smc_reg : smc_reg - smr_reg) : '0;
        e_l  = (xe != '0) ? ((sml_reg > smc_reg) ? sml_reg - smc_reg : smc_reg - sml_reg) : '0;
        e_d  = (ye + 1'b1 < h) ? ((smd_reg > smc_reg) ? smd_reg - smc_reg : smc_reg - smd_reg) : '0;
        e_u  = (ye != '0) ? ((smu_reg > smc_reg) ? smu_reg - smc_reg : smc_reg - smu_reg) : '0;
        dmax = e_r;
        if (e_l > dmax)
        begin
            dmax = e_l;
        end
        if (e_d > dmax)
        begin
            dmax = e_d;
        end
        if (e_u > dmax)
        begin
            dmax = e_u;
        end
        prod    = MW'(d_reg) * MW'(scale_reg) + MW'(2**(FRAC_BITS-1));
        st_full = prod >> FRAC_BITS;
    end

    // Line buffer port control.
    always_comb
    begin
        fp_addr  = ab;
        sp_addr  = ad;
        sm_addr  = ae;
        fp_we    = 1'b0;
        sp_we    = 1'b0;
        sm_we    = 1'b0;
        sm_wdata = vd_reg;
        unique case (state_reg)
            S_RD2:
            begin
                fp_addr = abu;
                sp_addr = adu;
                sm_addr = ae - 1'b1;
            end
            S_RD3:
            begin
                fp_addr = aa;
                fp_we   = act_a_reg;
                sm_addr = ae + 1'b1;
            end
            S_RD4:   sm_addr = aeu;
            S_RD5:   sm_addr = aed;
            S_W6:
            begin
                sp_addr = ac;
                sp_we   = act_c_reg;
            end
            S_W7:
            begin
                sm_addr = ad;
                sm_we   = act_d_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fp_we)
        begin
            fp_mem[fp_addr] <= va_reg;
        end
        else
        begin
            fp_rdata_reg <= fp_mem[fp_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_mem[sp_addr] <= vc_reg;
        end
        else
        begin
            sp_rdata_reg <= sp_mem[sp_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sm_mem[sm_addr] <= sm_wdata;
        end
        else
        begin
            sm_rdata_reg <= sm_mem[sm_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = (accept && take) ? S_RD1 : S_IDLE;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_RD4;
            S_RD4:   state_next = S_RD5;
            S_RD5:   state_next = S_W6;
            S_W6:    state_next = S_W7;
            S_W7:    state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:   state_next = done ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && take && in_frame)
        begin
            raw_win[mp] <= {s_axis_tdata, FRAC_BITS'(0)};
        end
        if (state_reg == S_RD1)
        begin
            va_reg <= div_taps(sum_a, k_a);
        end
        if (state_reg == S_RD2)
        begin
            fpb0_reg <= fp_rdata_reg;
            spd0_reg <= sp_rdata_reg;
            smc_reg  <= sm_rdata_reg;
        end
        if (state_reg == S_RD3)
        begin
            spd1_reg <= sp_rdata_reg;
            sml_reg  <= sm_rdata_reg;
            vb_reg   <= div_taps(sum_b, k_b);
        end
        if (state_reg == S_RD4)
        begin
            smr_reg <= sm_rdata_reg;
            if (act_b_reg)
            begin
                mid_win[mb] <= vb_reg;
            end
        end
        if (state_reg == S_RD5)
        begin
            smu_reg <= sm_rdata_reg;
            vc_reg  <= div_taps(sum_c, k_c);
        end
        if (state_reg == S_W6)
        begin
            smd_reg <= sm_rdata_reg;
            vd_reg  <= div_taps(sum_d, k_d);
        end
        if (state_reg == S_W7)
        begin
            d_reg <= dmax;
        end
        if (state_reg == S_MUL)
        begin
            st_reg <= (st_full > MW'(16'hFFFF)) ? 16'hFFFF : OUT_W'(st_full);
        end
        if (done && act_e_reg)
        begin
            out_h_reg    <= (32'(smc_reg) > 32'hFFFF) ? 16'hFFFF : OUT_W'(smc_reg);
            out_s_reg    <= st_reg;
            out_last_reg <= is_last;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_w_reg     <= RST_FRAME_DIM;
            cfg_h_reg     <= RST_FRAME_DIM;
            scale_reg     <= RST_STEEP_SCALE;
            t_reg         <= '0;
            act_p_reg     <= 1'b0;
            act_a_reg     <= 1'b0;
            act_b_reg     <= 1'b0;
            act_c_reg     <= 1'b0;
            act_d_reg     <= 1'b0;
            act_e_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  cfg_w_reg <= dim_t'(cfg_data);
                    CFG_FRAME_HEIGHT: cfg_h_reg <= dim_t'(cfg_data);
                    CFG_STEEP_SCALE:  scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && accept && take)
            begin
                act_p_reg <= in_frame;
                act_a_reg <= act_a;
                act_b_reg <= act_b;
                act_c_reg <= act_c;
                act_d_reg <= act_d;
                act_e_reg <= act_e;
            end
            if (frame_clr)
            begin
                t_reg <= '0;
            end
            else if (done)
            begin
                t_reg <= t_reg + 1'b1;
            end
            if (done && act_e_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_s_reg, out_h_reg};
    assign m_axis_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT && act_e_reg))
        else $error("result loaded outside the output step");

    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_axis_tvalid) && m_axis_tlast) |-> (t_reg == '0))
        else $error("frame position not restarted after the last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !done) |=> (state_reg == S_OUT && $stable(t_reg)))
        else $error("item retired while its result was blocked");

endmodule

### sv/hbs_pos.sv
// ----------------------------------------------------------------------------
// hbs_pos
// Raster position tracker for one processing stage: column, row, line
// buffer address of the pixel and of its vertical neighbors, and the linear
// index modulo three.
// ----------------------------------------------------------------------------
module hbs_pos #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           step,
    input  hbs_pkg::dim_t                  w,
    output hbs_pkg::dim_t                  x,
    output hbs_pkg::dim_t                  y,
    output logic [$clog2(3*MAX_WIDTH)-1:0] addr,
    output logic [$clog2(3*MAX_WIDTH)-1:0] addr_up,
    output logic [$clog2(3*MAX_WIDTH)-1:0] addr_dn,
    output hbs_pkg::mod3_t                 m3
);
    import hbs_pkg::*;

    localparam int AW = $clog2(3*MAX_WIDTH);

    dim_t          x_reg, x_next;
    dim_t          y_reg, y_next;
    mod3_t         row3_reg, row3_next;
    mod3_t         m3_reg, m3_next;
    logic [AW-1:0] addr_reg, addr_next;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        row3_next = row3_reg;
        m3_next   = m3_reg;
        addr_next = addr_reg;
        if (clear)
        begin
            x_next    = '0;
            y_next    = '0;
            row3_next = '0;
            m3_next   = '0;
            addr_next = '0;
        end
        else if (step)
        begin
            m3_next = mod3_inc(m3_reg);
            if (x_reg + 1'b1 == w)
            begin
                x_next    = '0;
                y_next    = y_reg + 1'b1;
                row3_next = mod3_inc(row3_reg);
                case (row3_next)
                    2'd1:    addr_next = AW'(MAX_WIDTH);
                    2'd2:    addr_next = AW'(2*MAX_WIDTH);
                    default: addr_next = '0;
                endcase
            end
            else
            begin
                x_next    = x_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            row3_reg <= '0;
            m3_reg   <= '0;
            addr_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            row3_reg <= row3_next;
            m3_reg   <= m3_next;
            addr_reg <= addr_next;
        end
    end

    assign x       = x_reg;
    assign y       = y_reg;
    assign m3      = m3_reg;
    assign addr    = addr_reg;
    assign addr_up = (row3_reg == 2'd0) ? addr_reg + AW'(2*MAX_WIDTH)
                                        : addr_reg - AW'(MAX_WIDTH);
    assign addr_dn = (row3_reg == 2'd2) ? addr_reg - AW'(2*MAX_WIDTH)
                                        : addr_reg + AW'(MAX_WIDTH);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the height blur and steepness stream core.
// Frames of heights and their drain transfers are sent under several size and
// scale settings and idle patterns. Every accepted transfer is fed to a local
// two-pass blur and steepness calculation, and each output transfer is
// compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb;
    import hbs_pkg::*;

    localparam int MAXW  = 1024;
    localparam int MAXH  = 1024;
    localparam int FRAC  = 8;
    localparam int DEPTH = 2 * MAXW + 2;
    localparam bit REQ_PIXEL = 1'b0;
    localparam bit REQ_DRAIN = 1'b1;

    typedef struct packed {
        bit       req;
        bit [7:0] height;
    } height_item_t;

    typedef struct packed {
        bit [15:0] smoothed;
        bit [15:0] steep;
        bit        last;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // height_in
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // smoothed_height, steepness
    logic        m_axis_tlast;   // last_pixel

    height_item_t  pending_heights[$];
    pixel_result_t expected_pixels[$];
    height_item_t  cur_item;
    int            src_idle;
    int            snk_stall;
    int            mismatches;

    int unsigned frame_w_reg;
    int unsigned frame_h_reg;
    int unsigned scale_reg;
    int unsigned pass1_rows[DEPTH];
    int unsigned pass2_rows[DEPTH];
    int unsigned blur_rows[DEPTH];
    int unsigned hwin[6];
    int          in_pos;

    height_blur_steepness_stream_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned tap_avg(input int unsigned s, input int unsigned k);
        if (k == 3)
            return (s + 1) / 3;
        if (k == 2)
            return (s + 1) >> 1;
        return s;
    endfunction

    function automatic int unsigned absdiff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int clamp_dim(input int unsigned v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic blur_predict(input height_item_t it);
        int w;
        int h;
        int n;
        int t;
        int i;
        int x;
        int y;
        int unsigned s;
        int unsigned k;
        int unsigned c;
        int unsigned d;
        longint unsigned st;
        pixel_result_t r;
        w = clamp_dim(frame_w_reg, MAXW);
        h = clamp_dim(frame_h_reg, MAXH);
        n = w * h;
        t = in_pos;
        if (t < n) begin
            if (it.req == REQ_DRAIN)
                return;
            hwin[t % 3] = int'(it.height) << FRAC;
        end else if (it.req == REQ_PIXEL) begin
            return;
        end
        i = t - 1;
        if (i >= 0 && i < n) begin
            x = i % w;
            s = hwin[i % 3];
            k = 1;
            if (x > 0) begin s += hwin[(i - 1) % 3]; k++; end
            if (x + 1 < w) begin s += hwin[(i + 1) % 3]; k++; end
            pass1_rows[i % DEPTH] = tap_avg(s, k);
        end
        i = t - 1 - w;
        if (i >= 0 && i < n) begin
            y = i / w;
            s = pass1_rows[i % DEPTH];
            k = 1;
            if (y > 0) begin s += pass1_rows[(i - w) % DEPTH]; k++; end
            if (y + 1 < h) begin s += pass1_rows[(i + w) % DEPTH]; k++; end
            hwin[3 + i % 3] = tap_avg(s, k);
        end
        i = t - 2 - w;
        if (i >= 0 && i < n) begin
            x = i % w;
            s = hwin[3 + i % 3];
            k = 1;
            if (x > 0) begin s += hwin[3 + (i - 1) % 3]; k++; end
            if (x + 1 < w) begin s += hwin[3 + (i + 1) % 3]; k++; end
            pass2_rows[i % DEPTH] = tap_avg(s, k);
        end
        i = t - 2 - 2 * w;
        if (i >= 0 && i < n) begin
            y = i / w;
            s = pass2_rows[i % DEPTH];
            k = 1;
            if (y > 0) begin s += pass2_rows[(i - w) % DEPTH]; k++; end
            if (y + 1 < h) begin s += pass2_rows[(i + w) % DEPTH]; k++; end
            blur_rows[i % DEPTH] = tap_avg(s, k);
        end
        i = t - 3 - 3 * w;
        if (i >= 0 && i < n) begin
            x = i % w;
            y = i / w;
            c = blur_rows[i % DEPTH];
            d = 0;
            if (x + 1 < w && absdiff(blur_rows[(i + 1) % DEPTH], c) > d)
                d = absdiff(blur_rows[(i + 1) % DEPTH], c);
            if (x > 0 && absdiff(blur_rows[(i - 1) % DEPTH], c) > d)
                d = absdiff(blur_rows[(i - 1) % DEPTH], c);
            if (y + 1 < h && absdiff(blur_rows[(i + w) % DEPTH], c) > d)
                d = absdiff(blur_rows[(i + w) % DEPTH], c);
            if (y > 0 && absdiff(blur_rows[(i - w) % DEPTH], c) > d)
                d = absdiff(blur_rows[(i - w) % DEPTH], c);
            st = (longint'(d) * scale_reg + (64'd1 << (FRAC - 1))) >> FRAC;
            r.smoothed = (c > 16'hFFFF) ? 16'hFFFF : c[15:0];
            r.steep    = (st > 16'hFFFF) ? 16'hFFFF : st[15:0];
            r.last     = (i == n - 1);
            expected_pixels.insert(expected_pixels.size(), r);
            in_pos = r.last ? 0 : t + 1;
            return;
        end
        in_pos = t + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                blur_predict(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_heights.size() > 0 && $urandom_range(99) >= src_idle) begin
                    cur_item = pending_heights.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_item.height;
                    s_axis_tuser  <= cur_item.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t e;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected transfer: data %h last %b", m_axis_tdata,
                                 m_axis_tlast);
                end else begin
                    e = expected_pixels.pop_front();
                    if (m_axis_tdata[15:0] !== e.smoothed || m_axis_tdata[31:16] !== e.steep
                        || m_axis_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected h %h s %h l %b, got h %h s %h l %b",
                                     e.smoothed, e.steep, e.last, m_axis_tdata[15:0],
                                     m_axis_tdata[31:16], m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        if (idx == CFG_FRAME_WIDTH) begin
            frame_w_reg = value & 32'h7FF;
            in_pos = 0;
        end else if (idx == CFG_FRAME_HEIGHT) begin
            frame_h_reg = value & 32'h7FF;
            in_pos = 0;
        end else begin
            scale_reg = value & 32'hFFFF;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_heights.size() == 0 && !s_axis_tvalid && expected_pixels.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic setup(input int unsigned w, input int unsigned h, input int unsigned sc);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_STEEP_SCALE, sc);
    endtask

    task automatic push(input bit req, input bit [7:0] hv);
        height_item_t it;
        it.req    = req;
        it.height = hv;
        pending_heights.insert(pending_heights.size(), it);
    endtask

    // pattern 0: random, 1: checkerboard of the extremes, 2: half extremes, half random.
    // noise inserts drains inside the frame and pixels among the drains.
    task automatic send_frame(input int pattern, input int noise, input int cut);
        int w;
        int h;
        int n;
        bit [7:0] v;
        w = clamp_dim(frame_w_reg, MAXW);
        h = clamp_dim(frame_h_reg, MAXH);
        n = w * h;
        for (int p = 0; p < n; p++) begin
            if ($urandom_range(99) < noise)
                push(REQ_DRAIN, 8'($urandom_range(255)));
            if (pattern == 1)
                v = (((p % w) + (p / w)) % 2) ? 8'd255 : 8'd0;
            else if (pattern == 2 && $urandom_range(1))
                v = $urandom_range(1) ? 8'd255 : 8'd0;
            else
                v = 8'($urandom_range(255));
            push(REQ_PIXEL, v);
            if (cut > 0 && p + 1 >= cut)
                return;
        end
        for (int q = 0; q < 3 * w + 3; q++) begin
            if ($urandom_range(99) < noise)
                push(REQ_PIXEL, 8'($urandom_range(255)));
            push(REQ_DRAIN, 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < noise)
            push(REQ_DRAIN, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int count;
        int w;
        int h;
        mismatches    = 0;
        src_idle      = 0;
        snk_stall     = 0;
        frame_w_reg   = 32'(RST_FRAME_DIM);
        frame_h_reg   = 32'(RST_FRAME_DIM);
        scale_reg     = 32'(RST_STEEP_SCALE);
        in_pos        = 0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        setup(0, 0, 65535);
        send_frame(0, 0, 0);
        push(REQ_DRAIN, 8'hA5);
        setup(4, 3, 65535);
        send_frame(1, 0, 0);
        setup(2, 1, 256);
        send_frame(2, 10, 0);
        setup(32'h0803, 1, 0);
        send_frame(2, 2, 0);
        setup(1, 2047, $urandom_range(65535));
        send_frame(0, 2, 0);
        setup(3, 2, 1);
        send_frame(1, 0, 5);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 77; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 77; end
                default: begin src_idle = 8; snk_stall = 8; end
            endcase
            w = $urandom_range(99) < 10 ? 0 : $urandom_range(1, 12);
            h = $urandom_range(99) < 10 ? 0 : $urandom_range(1, 8);
            setup(w, h, $urandom_range(99) < 20 ? 65535 : $urandom_range(65535));
            count = 0;
            while (count < 110) begin
                send_frame($urandom_range(99) < 70 ? 0 : 2, 4, 0);
                count = pending_heights.size();
            end
            if ($urandom_range(1))
                send_frame(0, 0, $urandom_range(1, 20));
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("** height_blur_steepness_stream_core: PASSED **");
        else
            $display("** height_blur_steepness_stream_core: FAILED **");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("** height_blur_steepness_stream_core: FAILED **");
        $finish;
    end

endmodule

### sim.f
sv/hbs_pkg.sv
sv/hbs_pos.sv
sv/height_blur_steepness_stream_core.sv
tb/sv/tb.sv
